// ===== src/ec_pkg.sv =====
package ec_pkg;

  localparam int DATA_W   = 32;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int DAYS_W   = 16;
  localparam int YEAR_W   = 8;
  localparam int DOY_W    = 9;
  localparam int MONTH_W  = 4;
  localparam int MDAY_W   = 5;
  localparam int REM_W    = 6;

  localparam logic [DATA_W-1:0] THRESHOLD_RESET = 32'd1451602800;

  localparam logic [REM_W-1:0] SEC_PER_MIN  = 6'd60;
  localparam logic [REM_W-1:0] MIN_PER_HOUR = 6'd60;
  localparam logic [REM_W-1:0] HOUR_PER_DAY = 6'd24;
  localparam logic [REM_W-1:0] DAYS_PER_WK  = 6'd7;

  // reciprocals, exact for every dividend that reaches each pass
  localparam logic [DATA_W-1:0] RECIP_60 = 32'h88888889;
  localparam logic [DATA_W-1:0] RECIP_24 = 32'hAAAAAAAB;
  localparam logic [DATA_W-1:0] RECIP_7  = 32'h24924925;
  localparam int SHIFT_60 = 37;
  localparam int SHIFT_24 = 36;
  localparam int SHIFT_7  = 32;

  // 1970-01-01 was a thursday, weekday code 5
  localparam logic [DATA_W-1:0] WDAY_BIAS = 32'd4;

  localparam int EPOCH_YEAR = 1970;
  localparam int EPOCH_MOD4 = EPOCH_YEAR % 4;
  // only century in range that is not a leap year
  localparam logic [YEAR_W-1:0] CENTURY_SKIP = 8'(2100 - EPOCH_YEAR);

  localparam logic [DOY_W-1:0] DAYS_LEAP_YEAR = 9'd366;
  localparam logic [DOY_W-1:0] DAYS_YEAR      = 9'd365;
  localparam logic [MONTH_W-1:0] LAST_MONTH   = 4'd11;
  localparam logic [MONTH_W-1:0] FEBRUARY     = 4'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SPLIT,
    ST_YEAR,
    ST_MONTH
  } state_t;

  typedef enum logic [1:0] {
    DIV_SEC,
    DIV_MIN,
    DIV_HOUR,
    DIV_WDAY
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_mul;
    logic     div_split;
    div_sel_t sel;
    logic     year_step;
    logic     month_step;
    logic     out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic year_last;
    logic month_last;
  } dp_sts_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] offset);
    logic [1:0] phase;
    phase = offset[1:0] + EPOCH_MOD4[1:0];
    return (phase == 2'd0) && (offset != CENTURY_SKIP);
  endfunction

  function automatic logic [DOY_W-1:0] year_len(input logic leap);
    return leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
  endfunction

  function automatic logic [MDAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [MDAY_W-1:0] len;
    case (m)
      4'd0:     len = 5'd31;
      FEBRUARY: len = leap ? 5'd29 : 5'd28;
      4'd2:     len = 5'd31;
      4'd3:     len = 5'd30;
      4'd4:     len = 5'd31;
      4'd5:     len = 5'd30;
      4'd6:     len = 5'd31;
      4'd7:     len = 5'd31;
      4'd8:     len = 5'd30;
      4'd9:     len = 5'd31;
      4'd10:    len = 5'd30;
      default:  len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [REM_W-1:0] divisor(input div_sel_t sel);
    logic [REM_W-1:0] d;
    case (sel)
      DIV_SEC:  d = SEC_PER_MIN;
      DIV_MIN:  d = MIN_PER_HOUR;
      DIV_HOUR: d = HOUR_PER_DAY;
      DIV_WDAY: d = DAYS_PER_WK;
      default:  d = SEC_PER_MIN;
    endcase
    return d;
  endfunction

  function automatic logic [DATA_W-1:0] recip(input div_sel_t sel);
    logic [DATA_W-1:0] m;
    case (sel)
      DIV_SEC:  m = RECIP_60;
      DIV_MIN:  m = RECIP_60;
      DIV_HOUR: m = RECIP_24;
      DIV_WDAY: m = RECIP_7;
      default:  m = RECIP_60;
    endcase
    return m;
  endfunction

endpackage

// ===== src/ec_datapath.sv =====
module ec_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  ec_pkg::ctl_cmd_t               cmd,
  output ec_pkg::dp_sts_t                sts,
  input  logic                           cfg_we,
  input  logic [ec_pkg::DATA_W-1:0]      cfg_data,
  input  logic [ec_pkg::DATA_W-1:0]      epoch_seconds,
  output logic [5:0]                     second_of_minute,
  output logic [5:0]                     minute_of_hour,
  output logic [4:0]                     hour_of_day,
  output logic [ec_pkg::DAYS_W-1:0]      total_days,
  output logic [2:0]                     weekday,
  output logic [ec_pkg::YEAR_W-1:0]      year_offset,
  output logic [ec_pkg::DOY_W-1:0]       day_in_year,
  output logic [ec_pkg::MONTH_W-1:0]     month_number,
  output logic [ec_pkg::MDAY_W-1:0]      day_in_month,
  output logic                           time_valid
);

  logic [ec_pkg::DATA_W-1:0]  threshold;
  logic [ec_pkg::DATA_W-1:0]  x;
  logic [ec_pkg::PROD_W-1:0]  prod;
  logic [5:0]                 sec;
  logic [5:0]                 min;
  logic [4:0]                 hour;
  logic [ec_pkg::DAYS_W-1:0]  days;
  logic [2:0]                 wday;
  logic [ec_pkg::YEAR_W-1:0]  year;
  logic [ec_pkg::DAYS_W-1:0]  doy;
  logic [ec_pkg::DOY_W-1:0]   rem;
  logic [ec_pkg::MONTH_W-1:0] month;
  logic                       valid_flag;

  logic [ec_pkg::DATA_W-1:0]  quot;
  logic [ec_pkg::REM_W-1:0]   rmd;
  logic                       leap;
  logic [ec_pkg::DOY_W-1:0]   ylen;
  logic [ec_pkg::MDAY_W-1:0]  mlen;

  // quotient from the registered reciprocal product
  always_comb begin
    case (cmd.sel)
      ec_pkg::DIV_SEC:  quot = ec_pkg::DATA_W'(prod[ec_pkg::PROD_W-1:ec_pkg::SHIFT_60]);
      ec_pkg::DIV_MIN:  quot = ec_pkg::DATA_W'(prod[ec_pkg::PROD_W-1:ec_pkg::SHIFT_60]);
      ec_pkg::DIV_HOUR: quot = ec_pkg::DATA_W'(prod[ec_pkg::PROD_W-1:ec_pkg::SHIFT_24]);
      default:          quot = ec_pkg::DATA_W'(prod[ec_pkg::PROD_W-1:ec_pkg::SHIFT_7]);
    endcase
  end

  // remainder is below 64, so the low bits are enough
  assign rmd = x[ec_pkg::REM_W-1:0] -
               ec_pkg::REM_W'(quot[ec_pkg::REM_W-1:0] * ec_pkg::divisor(cmd.sel));

  assign leap = ec_pkg::is_leap(year);
  assign ylen = ec_pkg::year_len(leap);
  assign mlen = ec_pkg::month_len(month, leap);

  assign sts.year_last  = doy < ec_pkg::DAYS_W'(ylen);
  assign sts.month_last = (month == ec_pkg::LAST_MONTH) ||
                          (rem < ec_pkg::DOY_W'(mlen));

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ec_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x          <= epoch_seconds;
      valid_flag <= epoch_seconds > threshold;
    end else if (cmd.div_mul) begin
      prod <= ec_pkg::PROD_W'(x) * ec_pkg::PROD_W'(ec_pkg::recip(cmd.sel));
    end else if (cmd.div_split) begin
      case (cmd.sel)
        ec_pkg::DIV_SEC: begin
          sec <= rmd;
          x   <= quot;
        end
        ec_pkg::DIV_MIN: begin
          min <= rmd;
          x   <= quot;
        end
        ec_pkg::DIV_HOUR: begin
          hour <= rmd[4:0];
          days <= quot[ec_pkg::DAYS_W-1:0];
          x    <= ec_pkg::DATA_W'(quot[ec_pkg::DAYS_W-1:0]) + ec_pkg::WDAY_BIAS;
        end
        default: begin
          wday <= rmd[2:0] + 3'd1;
          doy  <= days;
          year <= '0;
        end
      endcase
    end else if (cmd.year_step) begin
      if (sts.year_last) begin
        rem   <= doy[ec_pkg::DOY_W-1:0];
        month <= '0;
      end else begin
        doy  <= doy - ec_pkg::DAYS_W'(ylen);
        year <= year + ec_pkg::YEAR_W'(1);
      end
    end else if (cmd.month_step && !sts.month_last) begin
      rem   <= rem - ec_pkg::DOY_W'(mlen);
      month <= month + ec_pkg::MONTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      second_of_minute <= sec;
      minute_of_hour   <= min;
      hour_of_day      <= hour;
      total_days       <= days;
      weekday          <= wday;
      year_offset      <= year;
      day_in_year      <= doy[ec_pkg::DOY_W-1:0];
      month_number     <= month + ec_pkg::MONTH_W'(1);
      day_in_month     <= ec_pkg::MDAY_W'(rem + ec_pkg::DOY_W'(1));
      time_valid       <= valid_flag;
    end
  end

endmodule

// ===== src/ec_control.sv =====
module ec_control (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ec_pkg::dp_sts_t   sts,
  output ec_pkg::ctl_cmd_t  cmd
);

  ec_pkg::state_t   state;
  ec_pkg::state_t   state_next;
  ec_pkg::div_sel_t sel;
  ec_pkg::div_sel_t sel_next;
  logic             out_free;
  logic             done;

  assign out_free = !out_valid || out_ready;
  assign done     = (state == ec_pkg::ST_MONTH) && sts.month_last && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ec_pkg::ST_IDLE;
      sel       <= ec_pkg::DIV_SEC;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    case (state)
      ec_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = ec_pkg::ST_MUL;
          sel_next   = ec_pkg::DIV_SEC;
        end
      end
      ec_pkg::ST_MUL: begin
        state_next = ec_pkg::ST_SPLIT;
      end
      ec_pkg::ST_SPLIT: begin
        state_next = ec_pkg::ST_MUL;
        case (sel)
          ec_pkg::DIV_SEC:  sel_next = ec_pkg::DIV_MIN;
          ec_pkg::DIV_MIN:  sel_next = ec_pkg::DIV_HOUR;
          ec_pkg::DIV_HOUR: sel_next = ec_pkg::DIV_WDAY;
          default:          state_next = ec_pkg::ST_YEAR;
        endcase
      end
      ec_pkg::ST_YEAR: begin
        if (sts.year_last) state_next = ec_pkg::ST_MONTH;
      end
      ec_pkg::ST_MONTH: begin
        if (done) state_next = ec_pkg::ST_IDLE;
      end
      default: state_next = ec_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd.load       = 1'b0;
    cmd.div_mul    = 1'b0;
    cmd.div_split  = 1'b0;
    cmd.sel        = sel;
    cmd.year_step  = 1'b0;
    cmd.month_step = 1'b0;
    cmd.out_load   = 1'b0;
    case (state)
      ec_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ec_pkg::ST_MUL: begin
        cmd.div_mul = 1'b1;
      end
      ec_pkg::ST_SPLIT: begin
        cmd.div_split = 1'b1;
      end
      ec_pkg::ST_YEAR: begin
        cmd.year_step = 1'b1;
      end
      ec_pkg::ST_MONTH: begin
        cmd.month_step = 1'b1;
        cmd.out_load   = done;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/epoch_to_calendar.sv =====
// one item at a time from input transfer to result valid, worked in steps:
// four reciprocal-multiply divisions (/60, /60, /24, /7), each a multiply and a split step, then
// one step per year from 1970 plus one and one step per month plus one
// output stalls hold the last month step and so delay the next result
// the next input is taken while a finished result waits for its output transfer
// reset: synchronous, active high; clears control state and loads the default threshold
module epoch_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  second_of_minute,
  output logic [5:0]  minute_of_hour,
  output logic [4:0]  hour_of_day,
  output logic [15:0] total_days,
  output logic [2:0]  weekday,
  output logic [7:0]  year_offset,
  output logic [8:0]  day_in_year,
  output logic [3:0]  month_number,
  output logic [4:0]  day_in_month,
  output logic        time_valid
);

  ec_pkg::ctl_cmd_t cmd;
  ec_pkg::dp_sts_t  sts;

  assign cfg_ready = 1'b1;

  ec_control u_control (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ec_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .epoch_seconds    (epoch_seconds),
    .second_of_minute (second_of_minute),
    .minute_of_hour   (minute_of_hour),
    .hour_of_day      (hour_of_day),
    .total_days       (total_days),
    .weekday          (weekday),
    .year_offset      (year_offset),
    .day_in_year      (day_in_year),
    .month_number     (month_number),
    .day_in_month     (day_in_month),
    .time_valid       (time_valid)
  );

endmodule
